// ===== rtl/bms_pkg.sv =====
// ----------------------------------------------------------------------------
// Bracket match scanner package
// Shared widths, codes, the request record between front and back, and the
// bracket pair lookup.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int DEPTH_WIDTH = 16;
    localparam int CH_W        = 8;
    localparam int COL_W       = 16;
    localparam int ROW_W       = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CH_W-1:0]        ESC_RESET = 8'h5C;
    localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = '1;

    // Input request kinds.
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_CHAR  = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_SEARCHING = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NO_MATCH  = 2'd2,
        ST_NO_OPEN   = 2'd3
    } status_t;

    // Operations handed from the front to the back.
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_NO_OPEN = 2'd1,
        OP_CHAR    = 2'd2,
        OP_END     = 2'd3
    } op_code_t;

    typedef struct packed {
        op_code_t          code;
        logic [CH_W-1:0]   ch;
        logic [CH_W-1:0]   partner;
        logic              backward;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } op_t;

    typedef struct packed {
        logic            hit;
        logic            backward;
        logic [CH_W-1:0] partner;
    } bracket_t;

    // Closing brackets send the search toward the buffer start.
    function automatic bracket_t classify(input logic [CH_W-1:0] c);
        bracket_t r;
        r = '0;
        case (c)
            8'h7B: begin r.hit = 1'b1; r.backward = 1'b0; r.partner = 8'h7D; end
            8'h7D: begin r.hit = 1'b1; r.backward = 1'b1; r.partner = 8'h7B; end
            8'h28: begin r.hit = 1'b1; r.backward = 1'b0; r.partner = 8'h29; end
            8'h29: begin r.hit = 1'b1; r.backward = 1'b1; r.partner = 8'h28; end
            8'h5B: begin r.hit = 1'b1; r.backward = 1'b0; r.partner = 8'h5D; end
            8'h5D: begin r.hit = 1'b1; r.backward = 1'b1; r.partner = 8'h5B; end
            8'h60: begin r.hit = 1'b1; r.backward = 1'b0; r.partner = 8'h27; end
            8'h27: begin r.hit = 1'b1; r.backward = 1'b1; r.partner = 8'h60; end
            8'h3C: begin r.hit = 1'b1; r.backward = 1'b0; r.partner = 8'h3E; end
            8'h3E: begin r.hit = 1'b1; r.backward = 1'b1; r.partner = 8'h3C; end
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bracket_match_scanner_core.sv =====
// ----------------------------------------------------------------------------
// Bracket match scanner core
// Finds the bracket matching a start bracket from a stream of characters.
// ----------------------------------------------------------------------------
// The core takes one request per clock cycle unless the queue is full, and
// produces at most one result per request. Requests are decoded in the
// front, placed in a four-entry queue, and executed by the back at one
// operation per cycle while its result register is free or being taken, a
// rate set by the single compare and depth counter update of the back.
// A request is written into the queue and then executed into the result
// register, from which its result is offered. The input stalls only when
// the queue is full, which happens only while the output is held off.
module bracket_match_scanner_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // escape_char
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,       // ch[7:0], before_ch[15:8], col[31:16], row[51:32]
    input  logic [1:0]  s_tuser,       // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // backward[0], match_col[16:1], match_row[36:17]
    output logic [1:0]  m_tuser        // status[1:0]
);

    logic                          push;
    logic                          pop;
    logic                          full;
    logic                          empty;
    bms_pkg::op_t                  push_op;
    bms_pkg::op_t                  head;
    logic                          res_backward;
    logic [bms_pkg::COL_W-1:0]     res_col;
    logic [bms_pkg::ROW_W-1:0]     res_row;

    bms_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (s_tvalid),
        .in_kind      (s_tuser),
        .in_ch        (s_tdata[7:0]),
        .in_before_ch (s_tdata[15:8]),
        .in_col       (s_tdata[31:16]),
        .in_row       (s_tdata[51:32]),
        .queue_full   (full),
        .in_ready     (s_tready),
        .push         (push),
        .push_op      (push_op)
    );

    bms_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .full    (full),
        .empty   (empty),
        .head    (head)
    );

    bms_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_status   (m_tuser),
        .out_backward (res_backward),
        .out_col      (res_col),
        .out_row      (res_row)
    );

    assign m_tdata = {3'b000, res_row, res_col, res_backward};

endmodule

// ===== rtl/bms_front.sv =====
// ----------------------------------------------------------------------------
// Bracket match scanner front
// Holds the escape register, decodes each incoming request into an operation
// and drops requests that can never produce a result or change state.
// ----------------------------------------------------------------------------
module bms_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bms_pkg::CH_W-1:0]      cfg_wr_data,
    input  logic                          in_valid,
    input  logic [1:0]                    in_kind,
    input  logic [bms_pkg::CH_W-1:0]      in_ch,
    input  logic [bms_pkg::CH_W-1:0]      in_before_ch,
    input  logic [bms_pkg::COL_W-1:0]     in_col,
    input  logic [bms_pkg::ROW_W-1:0]     in_row,
    input  logic                          queue_full,
    output logic                          in_ready,
    output logic                          push,
    output bms_pkg::op_t                  push_op
);

    logic [bms_pkg::CH_W-1:0] esc_reg;
    logic [bms_pkg::CH_W-1:0] esc_next;
    logic                     escaped;
    logic                     keep;
    bms_pkg::bracket_t        cls;

    always_comb begin
        esc_next = cfg_wr_en ? cfg_wr_data : esc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg <= bms_pkg::ESC_RESET;
        end else begin
            esc_reg <= esc_next;
        end
    end

    assign in_ready = !queue_full;
    assign escaped  = (in_col != '0) && (in_before_ch == esc_reg);
    assign cls      = bms_pkg::classify(in_ch);

    always_comb begin
        push_op          = '0;
        push_op.ch       = in_ch;
        push_op.col      = in_col;
        push_op.row      = in_row;
        push_op.code     = bms_pkg::OP_END;
        keep             = 1'b0;
        case (in_kind)
            bms_pkg::KIND_START: begin
                keep = 1'b1;
                if (cls.hit && !escaped) begin
                    push_op.code     = bms_pkg::OP_START;
                    push_op.partner  = cls.partner;
                    push_op.backward = cls.backward;
                end else begin
                    push_op.code = bms_pkg::OP_NO_OPEN;
                end
            end
            bms_pkg::KIND_CHAR: begin
                // An escaped character never counts, whatever the search state.
                keep         = !escaped;
                push_op.code = bms_pkg::OP_CHAR;
            end
            bms_pkg::KIND_END: begin
                keep         = 1'b1;
                push_op.code = bms_pkg::OP_END;
            end
            default: keep = 1'b0;
        endcase
    end

    assign push = in_valid && in_ready && keep;

endmodule

// ===== rtl/bms_queue.sv =====
// ----------------------------------------------------------------------------
// Bracket match scanner operation queue
// A short first-in first-out buffer that lets the front and back stall
// independently.
// ----------------------------------------------------------------------------
module bms_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  bms_pkg::op_t push_op,
    input  logic         pop,
    output logic         full,
    output logic         empty,
    output bms_pkg::op_t head
);

    bms_pkg::op_t                  mem_reg [bms_pkg::QUEUE_DEPTH];
    logic [bms_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [bms_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [bms_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [bms_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [bms_pkg::QCNT_W-1:0]    count_reg;
    logic [bms_pkg::QCNT_W-1:0]    count_next;

    assign full  = (count_reg == bms_pkg::QCNT_W'(bms_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/bms_back.sv =====
// ----------------------------------------------------------------------------
// Bracket match scanner back
// Keeps the search state and nesting depth, executes queued operations and
// holds the result register for the output channel.
// ----------------------------------------------------------------------------
module bms_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              empty,
    input  bms_pkg::op_t                      head,
    output logic                              pop,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [1:0]                        out_status,
    output logic                              out_backward,
    output logic [bms_pkg::COL_W-1:0]         out_col,
    output logic [bms_pkg::ROW_W-1:0]         out_row
);

    logic                              searching_reg, searching_next;
    logic [bms_pkg::CH_W-1:0]          own_reg, own_next;
    logic [bms_pkg::CH_W-1:0]          partner_reg, partner_next;
    logic [bms_pkg::DEPTH_WIDTH-1:0]   depth_reg, depth_next, depth_dec;
    logic                              backward_reg, backward_next;

    logic                              valid_reg, valid_next;
    bms_pkg::status_t                  status_reg, status_next;
    logic                              rback_reg, rback_next;
    logic [bms_pkg::COL_W-1:0]         col_reg, col_next;
    logic [bms_pkg::ROW_W-1:0]         row_reg, row_next;
    logic                              emit;

    // The result register frees up in the same cycle it is taken.
    assign pop = !empty && (!valid_reg || out_ready);

    assign depth_dec = (depth_reg == '0) ? '0 : depth_reg - 1'b1;

    always_comb begin
        searching_next = searching_reg;
        own_next       = own_reg;
        partner_next   = partner_reg;
        depth_next     = depth_reg;
        backward_next  = backward_reg;
        emit           = 1'b0;
        status_next    = status_reg;
        rback_next     = rback_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        if (pop) begin
            case (head.code)
                bms_pkg::OP_START: begin
                    searching_next = 1'b1;
                    own_next       = head.ch;
                    partner_next   = head.partner;
                    backward_next  = head.backward;
                    depth_next     = bms_pkg::DEPTH_WIDTH'(1);
                    emit           = 1'b1;
                    status_next    = bms_pkg::ST_SEARCHING;
                    rback_next     = head.backward;
                    col_next       = '0;
                    row_next       = '0;
                end
                bms_pkg::OP_NO_OPEN: begin
                    searching_next = 1'b0;
                    emit           = 1'b1;
                    status_next    = bms_pkg::ST_NO_OPEN;
                    rback_next     = 1'b0;
                    col_next       = '0;
                    row_next       = '0;
                end
                bms_pkg::OP_CHAR: begin
                    if (searching_reg) begin
                        if (head.ch == own_reg) begin
                            if (depth_reg != bms_pkg::DEPTH_MAX) begin
                                depth_next = depth_reg + 1'b1;
                            end
                        end else if (head.ch == partner_reg) begin
                            depth_next = depth_dec;
                            if (depth_dec == '0) begin
                                searching_next = 1'b0;
                                emit           = 1'b1;
                                status_next    = bms_pkg::ST_FOUND;
                                rback_next     = backward_reg;
                                col_next       = head.col;
                                row_next       = head.row;
                            end
                        end
                    end
                end
                bms_pkg::OP_END: begin
                    if (searching_reg) begin
                        searching_next = 1'b0;
                        emit           = 1'b1;
                        status_next    = bms_pkg::ST_NO_MATCH;
                        rback_next     = backward_reg;
                        col_next       = '0;
                        row_next       = '0;
                    end
                end
                default: emit = 1'b0;
            endcase
        end
        if (emit) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            searching_reg <= 1'b0;
            own_reg       <= '0;
            partner_reg   <= '0;
            depth_reg     <= '0;
            backward_reg  <= 1'b0;
            valid_reg     <= 1'b0;
        end else begin
            searching_reg <= searching_next;
            own_reg       <= own_next;
            partner_reg   <= partner_next;
            depth_reg     <= depth_next;
            backward_reg  <= backward_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        rback_reg  <= rback_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
    end

    assign out_valid    = valid_reg;
    assign out_status   = status_reg;
    assign out_backward = rback_reg;
    assign out_col      = col_reg;
    assign out_row      = row_reg;

    // A running search always has at least the start bracket open.
    a_depth_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        searching_reg |-> (depth_reg != '0))
        else $error("search active with zero nesting depth");

    a_start_searches: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && (head.code == bms_pkg::OP_START)) |=>
            (searching_reg && valid_reg && (status_reg == bms_pkg::ST_SEARCHING)))
        else $error("start request did not open a search");

    a_position_only_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && (status_reg != bms_pkg::ST_FOUND)) |->
            ((col_reg == '0) && (row_reg == '0)))
        else $error("position reported without a match");

    a_search_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !$past(valid_reg && !out_ready) &&
            ((status_reg == bms_pkg::ST_FOUND) || (status_reg == bms_pkg::ST_NO_MATCH) ||
             (status_reg == bms_pkg::ST_NO_OPEN))) |-> !searching_reg)
        else $error("search still active after a closing result");

endmodule

// ===== tb/bracket_match_scanner_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bracket match scanner core testbench
// Streams start, character, region-end and unused-kind requests into the core
// and checks each returned result against a cycle-free model of the search.
// The run steps through several escape characters and through phases where
// mostly the result side, mostly the request side or neither side idles.
// ----------------------------------------------------------------------------
module bracket_match_scanner_core_test;

    // Kind code that the core must ignore.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Opening brackets at even positions, each partner right after it.
    localparam logic [7:0] BRACKETS [10] = '{
        8'h7B, 8'h7D,   // { }
        8'h28, 8'h29,   // ( )
        8'h5B, 8'h5D,   // [ ]
        8'h60, 8'h27,   // ` '
        8'h3C, 8'h3E    // < >
    };

    typedef struct {
        logic [1:0]                kind;
        logic [bms_pkg::CH_W-1:0]  ch;
        logic [bms_pkg::CH_W-1:0]  prev_ch;
        logic [bms_pkg::COL_W-1:0] col;
        logic [bms_pkg::ROW_W-1:0] row;
    } scan_req_t;

    typedef struct {
        bms_pkg::status_t          status;
        logic                      backward;
        logic [bms_pkg::COL_W-1:0] col;
        logic [bms_pkg::ROW_W-1:0] row;
    } scan_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    bracket_match_scanner_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #1 aclk = ~aclk;

    scan_req_t    pending_reqs[$];
    scan_result_t expected_results[$];
    scan_req_t    cur_req;
    bit           req_fired = 1'b0;
    int           send_idle_pct = 20;
    int           recv_idle_pct = 75;
    int           error_count = 0;

    // Shadow of the search state.
    logic [7:0]                      esc_shadow = bms_pkg::ESC_RESET;
    logic                            in_search = 1'b0;
    logic [7:0]                      own_ch = '0;
    logic [7:0]                      mate_ch = '0;
    logic [bms_pkg::DEPTH_WIDTH-1:0] nest = '0;
    logic                            walk_back = 1'b0;

    task automatic report_mismatch(input string what);
        $display("%0t: MISMATCH %s", $realtime, what);
        error_count++;
    endtask

    function automatic bit is_escaped(input scan_req_t r, input logic [7:0] esc);
        return (r.col != 0) && (r.prev_ch == esc);
    endfunction

    task automatic predict_scan(input scan_req_t r);
        scan_result_t res;
        int           hit;
        bit           esc;
        hit = -1;
        esc = is_escaped(r, esc_shadow);
        res = '{bms_pkg::ST_SEARCHING, 1'b0, '0, '0};
        case (r.kind)
            bms_pkg::KIND_START: begin
                for (int i = 9; i >= 0; i--)
                    if (r.ch == BRACKETS[i]) hit = i;
                if (hit < 0 || esc) begin
                    in_search = 1'b0;
                    res.status = bms_pkg::ST_NO_OPEN;
                end else begin
                    own_ch = r.ch;
                    mate_ch = BRACKETS[hit ^ 1];
                    walk_back = hit[0];
                    nest = bms_pkg::DEPTH_WIDTH'(1);
                    in_search = 1'b1;
                    res.backward = walk_back;
                end
                expected_results.push_back(res);
            end
            bms_pkg::KIND_CHAR: begin
                if (in_search && !esc) begin
                    if (r.ch == own_ch) begin
                        if (nest != bms_pkg::DEPTH_MAX) nest = nest + 1'b1;
                    end else if (r.ch == mate_ch) begin
                        if (nest != 0) nest = nest - 1'b1;
                        if (nest == 0) begin
                            in_search = 1'b0;
                            res = '{bms_pkg::ST_FOUND, walk_back, r.col, r.row};
                            expected_results.push_back(res);
                        end
                    end
                end
            end
            bms_pkg::KIND_END: begin
                if (in_search) begin
                    in_search = 1'b0;
                    res.status = bms_pkg::ST_NO_MATCH;
                    res.backward = walk_back;
                    expected_results.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    // Acceptance, prediction and result checking all happen at the rising edge.
    always @(posedge aclk) begin
        scan_result_t want;
        req_fired = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d", m_tuser));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  m_tuser, want.status));
                    if (m_tdata[0] !== want.backward)
                        report_mismatch($sformatf("backward %0b, wanted %0b",
                                                  m_tdata[0], want.backward));
                    if (m_tdata[16:1] !== want.col)
                        report_mismatch($sformatf("match_col %0d, wanted %0d",
                                                  m_tdata[16:1], want.col));
                    if (m_tdata[36:17] !== want.row)
                        report_mismatch($sformatf("match_row %0d, wanted %0d",
                                                  m_tdata[36:17], want.row));
                end
            end
            if (s_tvalid && s_tready) begin
                req_fired = 1'b1;
                predict_scan(cur_req);
            end
        end
    end

    // Request driver.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_fired) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {4'b0, cur_req.row, cur_req.col, cur_req.prev_ch, cur_req.ch};
                s_tuser <= cur_req.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result back-pressure.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic add_req(input logic [1:0] kind, input logic [7:0] ch,
                           input logic [7:0] prev_ch, input logic [15:0] col,
                           input logic [19:0] row);
        scan_req_t r;
        r = '{kind, ch, prev_ch, col, row};
        pending_reqs.push_back(r);
    endtask

    function automatic logic [7:0] rand_before();
        return ($urandom_range(0, 99) < 30) ? esc_shadow : 8'($urandom);
    endfunction

    function automatic logic [15:0] rand_col();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return '0;
        if (pick < 20) return '1;
        return 16'($urandom);
    endfunction

    function automatic logic [19:0] rand_row();
        return ($urandom_range(0, 99) < 5) ? 20'hFFFFF : 20'($urandom);
    endfunction

    // One search: a start bracket, a random body tracked to its match, and
    // sometimes a region end or an abandoned search instead.
    task automatic add_search();
        scan_req_t r;
        int        idx;
        int        body_len;
        int        depth;
        int        pick;
        logic [7:0] own;
        logic [7:0] mate;
        idx = $urandom_range(0, 9);
        own = BRACKETS[idx];
        mate = BRACKETS[idx ^ 1];
        r = '{bms_pkg::KIND_START, own, rand_before(), rand_col(), rand_row()};
        pending_reqs.push_back(r);
        if (is_escaped(r, esc_shadow)) return;
        depth = 1;
        body_len = $urandom_range(0, 14);
        for (int i = 0; i < body_len && depth > 0; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) r.ch = mate;
            else if (pick < 55) r.ch = own;
            else if (pick < 70) r.ch = BRACKETS[$urandom_range(0, 9)];
            else r.ch = 8'($urandom);
            r.kind = bms_pkg::KIND_CHAR;
            r.prev_ch = rand_before();
            r.col = rand_col();
            r.row = rand_row();
            if (!is_escaped(r, esc_shadow)) begin
                if (r.ch == own) depth++;
                else if (r.ch == mate) depth--;
            end
            pending_reqs.push_back(r);
        end
        if (depth > 0 && $urandom_range(0, 99) < 60)
            add_req(bms_pkg::KIND_END, 8'($urandom), rand_before(), rand_col(), rand_row());
    endtask

    task automatic add_random(input int count);
        int goal;
        goal = pending_reqs.size() + count;
        while (pending_reqs.size() < goal) begin
            if ($urandom_range(0, 99) < 85) begin
                add_search();
            end else begin
                add_req(2'($urandom_range(0, 3)),
                        ($urandom_range(0, 1) != 0) ? BRACKETS[$urandom_range(0, 9)]
                                                    : 8'($urandom),
                        rand_before(), rand_col(), rand_row());
            end
        end
    endtask

    // Waits until every request is in and every result is out, then lets the
    // pipeline settle since some requests produce no result.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_escape(input logic [7:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        esc_shadow = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, escape character at its reset value.
        add_req(bms_pkg::KIND_CHAR, 8'h29, 8'h20, 16'd3, 20'd1);
        add_req(bms_pkg::KIND_END, 8'h00, 8'h00, 16'd0, 20'd0);
        add_req(KIND_UNUSED, 8'h28, 8'h20, 16'd1, 20'd1);
        add_req(bms_pkg::KIND_START, 8'h61, 8'h20, 16'd4, 20'd2);
        add_req(bms_pkg::KIND_START, 8'h28, 8'h5C, 16'd5, 20'd2);
        // A leading escape at column zero does not count.
        add_req(bms_pkg::KIND_START, 8'h28, 8'h5C, 16'd0, 20'd3);
        add_req(bms_pkg::KIND_CHAR, 8'h28, 8'h5C, 16'd1, 20'd3);
        add_req(bms_pkg::KIND_CHAR, 8'h28, 8'h41, 16'd2, 20'd3);
        add_req(KIND_UNUSED, 8'h29, 8'h41, 16'd3, 20'd3);
        add_req(bms_pkg::KIND_CHAR, 8'h29, 8'h28, 16'd3, 20'd3);
        add_req(bms_pkg::KIND_CHAR, 8'h29, 8'h5C, 16'd4, 20'd3);
        add_req(bms_pkg::KIND_CHAR, 8'h29, 8'hFF, 16'hFFFF, 20'hFFFFF);
        add_req(bms_pkg::KIND_START, 8'h7D, 8'hFF, 16'hFFFF, 20'hFFFFF);
        add_req(bms_pkg::KIND_CHAR, 8'h7B, 8'h00, 16'd0, 20'd0);
        add_req(bms_pkg::KIND_START, 8'h60, 8'h20, 16'd7, 20'd9);
        add_req(bms_pkg::KIND_CHAR, 8'h27, 8'h20, 16'd8, 20'd9);
        add_req(bms_pkg::KIND_START, 8'h27, 8'h20, 16'd8, 20'd9);
        add_req(bms_pkg::KIND_CHAR, 8'h60, 8'h20, 16'd7, 20'd9);
        // A new start drops the running search.
        add_req(bms_pkg::KIND_START, 8'h5B, 8'h20, 16'd1, 20'd4);
        add_req(bms_pkg::KIND_START, 8'h3C, 8'h20, 16'd2, 20'd4);
        add_req(bms_pkg::KIND_CHAR, 8'h3E, 8'h20, 16'd9, 20'd4);
        add_req(bms_pkg::KIND_START, 8'h3E, 8'h20, 16'd2, 20'd5);
        add_req(bms_pkg::KIND_END, 8'h00, 8'h00, 16'd0, 20'd0);
        add_req(bms_pkg::KIND_START, 8'h5D, 8'h20, 16'd2, 20'd6);
        add_req(bms_pkg::KIND_END, 8'hFF, 8'hFF, 16'hFFFF, 20'hFFFFF);
        add_req(bms_pkg::KIND_START, 8'h7B, 8'h20, 16'd2, 20'd7);
        add_req(bms_pkg::KIND_START, 8'h78, 8'h20, 16'd3, 20'd7);
        add_req(bms_pkg::KIND_CHAR, 8'h7D, 8'h20, 16'd4, 20'd7);

        write_escape(8'h00);
        add_random(600);

        write_escape(8'hFF);
        send_idle_pct = 75;
        recv_idle_pct = 20;
        add_random(550);

        // An opening bracket as escape character, and no idling at all.
        write_escape(8'h7B);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(550);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #200us;
        $display("simulation failed");
        $finish;
    end

endmodule
